@@ rtl/ray_sphere_closest_hit_macros.svh @@
// Assertion macros shared by the ray-sphere closest-hit RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef RAY_SPHERE_CLOSEST_HIT_MACROS_SVH
`define RAY_SPHERE_CLOSEST_HIT_MACROS_SVH

// checked only out of reset
`define RSCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define RSCH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/rsch_pkg.sv @@
// Types and constants for the ray-sphere closest-hit block.
// Used by rsch_ctrl, rsch_datapath and ray_sphere_closest_hit.
package rsch_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned RAD_W     = 31;
  localparam int unsigned WIDE_W    = 66;  // |a|, |h|, ee, c, sqrt(disc)
  localparam int unsigned MUL_STEPS = 10;
  localparam int unsigned MS_EE     = 3;   // first e.e product
  localparam int unsigned MS_H      = 6;   // first d.e product
  localparam int unsigned MS_RR     = 9;   // r*r product

  localparam logic [30:0] T_MAX    = 31'h7FFF_FFFF;
  localparam logic [7:0]  COLOR_ON = 8'hFF;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CAST = 1'b1;

  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_Z = 2'd2;
  localparam logic [1:0] CFG_COUNT    = 2'd3;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_RD   = 12'b0000_0000_0010,
    ST_MUL  = 12'b0000_0000_0100,
    ST_CHK1 = 12'b0000_0000_1000,
    ST_WMUL = 12'b0000_0001_0000,
    ST_CHK2 = 12'b0000_0010_0000,
    ST_SQRT = 12'b0000_0100_0000,
    ST_CHK3 = 12'b0000_1000_0000,
    ST_DIV  = 12'b0001_0000_0000,
    ST_CAND = 12'b0010_0000_0000,
    ST_NXT  = 12'b0100_0000_0000,
    ST_FIN  = 12'b1000_0000_0000
  } state_e;

  typedef struct packed {
    logic              tbl_wr;
    logic              ray_ld;
    logic              k_inc;
    logic              rd_en;
    logic              acc_clr;
    logic              mul_vld;
    logic [3:0]        mul_step;
    logic              wmul_start;
    logic              wmul_step;
    logic              sqrt_start;
    logic              sqrt_step;
    logic              div_start;
    logic              div_step;
    logic              cand;
    logic              res_ld;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic a_miss;
    logic disc_miss;
    logic root_miss;
  } sts_t;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
    logic [RAD_W-1:0]   r;
  } entry_t;

endpackage

@@ rtl/ray_sphere_closest_hit.sv @@
// Load item: writes one table entry. Cast item: each tested sphere takes the
// products (one 33x33 product a cycle), then, unless it misses, a shift-add
// multiply, a square root and a divide; a cast gives its result once the last of
// its n spheres is through, n being the sphere count capped at MAX_SPHERES.
// One item is in flight at a time. Reset clears origin and count to 0; the
// sphere table holds no reset value and must be loaded before use.
module ray_sphere_closest_hit import rsch_pkg::*; #(
  parameter int unsigned MAX_SPHERES = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [31:0]               cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      cmd_i,
  input  logic [3:0]                slot_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] point_z_i,
  input  logic [RAD_W-1:0]          radius_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      hit_o,
  output logic [3:0]                hit_index_o,
  output logic [30:0]               distance_t_o,
  output logic [7:0]                red_o,
  output logic [7:0]                green_o,
  output logic [7:0]                blue_o
);

  cmd_t cmd;
  sts_t sts;

  rsch_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rsch_datapath #(
    .MAX_SPHERES (MAX_SPHERES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .slot_i       (slot_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .radius_i     (radius_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .hit_o        (hit_o),
    .hit_index_o  (hit_index_o),
    .distance_t_o (distance_t_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

endmodule

@@ rtl/rsch_ctrl.sv @@
// Sequencer for the ray-sphere closest-hit block: walks each sphere through
// product, wide multiply, square root and divide phases. Uses rsch_pkg.
`include "ray_sphere_closest_hit_macros.svh"
module rsch_ctrl import rsch_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic cmd_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam int unsigned DIV_STEPS = WIDE_W + FRAC_BITS;
  localparam int unsigned CW        = $clog2(DIV_STEPS);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_LOAD) begin
            cmd_o.tbl_wr = 1'b1;
          end else begin
            cmd_o.ray_ld = 1'b1;
            state_d      = sts_i.empty ? ST_FIN : ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.acc_clr = 1'b1;
        cnt_d         = '0;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_q < CW'(MUL_STEPS)) begin
          cmd_o.mul_vld  = 1'b1;
          cmd_o.mul_step = 4'(cnt_q);
        end
        if (cnt_q == CW'(MUL_STEPS)) begin
          cnt_d   = '0;
          state_d = ST_CHK1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_CHK1: begin
        if (sts_i.a_miss) begin
          state_d = ST_NXT;
        end else begin
          cmd_o.wmul_start = 1'b1;
          cnt_d            = '0;
          state_d          = ST_WMUL;
        end
      end
      ST_WMUL: begin
        cmd_o.wmul_step = 1'b1;
        if (cnt_q == CW'(WIDE_W - 1)) begin
          cnt_d   = '0;
          state_d = ST_CHK2;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_CHK2: begin
        if (sts_i.disc_miss) begin
          state_d = ST_NXT;
        end else begin
          cmd_o.sqrt_start = 1'b1;
          cnt_d            = '0;
          state_d          = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == CW'(WIDE_W - 1)) begin
          cnt_d   = '0;
          state_d = ST_CHK3;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_CHK3: begin
        if (sts_i.root_miss) begin
          state_d = ST_NXT;
        end else begin
          cmd_o.div_start = 1'b1;
          cnt_d           = '0;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CW'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_CAND;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_CAND: begin
        cmd_o.cand = 1'b1;
        state_d    = ST_NXT;
      end
      ST_NXT: begin
        if (sts_i.last) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = ST_RD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.res_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  `RSCH_ASSERT(a_res_free, cmd_o.res_ld |-> (!out_valid_q || !out_stall_i), "result overwrite")
  `RSCH_ASSERT(a_mul_cnt, (state_q == ST_MUL) |-> (cnt_q <= CW'(MUL_STEPS)), "product count")
  `RSCH_ASSERT(a_out_src, $rose(out_valid_q) |-> ($past(state_q) == ST_FIN), "stray result")

endmodule

@@ rtl/rsch_datapath.sv @@
// Datapath: config registers, sphere table, product accumulators, shift-add
// wide multipliers, restoring square root and divider. Uses rsch_pkg.
`include "ray_sphere_closest_hit_macros.svh"
module rsch_datapath import rsch_pkg::*; #(
  parameter int unsigned MAX_SPHERES = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [31:0]               cfg_data_i,
  input  logic [3:0]                slot_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] point_z_i,
  input  logic [RAD_W-1:0]          radius_i,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  output logic                      hit_o,
  output logic [3:0]                hit_index_o,
  output logic [30:0]               distance_t_o,
  output logic [7:0]                red_o,
  output logic [7:0]                green_o,
  output logic [7:0]                blue_o
);

  localparam int unsigned IW  = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int unsigned KW  = $clog2(MAX_SPHERES + 1);
  localparam int unsigned NW  = WIDE_W + FRAC_BITS;
  localparam int unsigned PW  = 2 * WIDE_W;

  // configuration
  logic signed [COORD_W-1:0] org_x_q, org_y_q, org_z_q;
  logic [4:0]                count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X: org_x_q <= cfg_data_i;
        CFG_ORIGIN_Y: org_y_q <= cfg_data_i;
        CFG_ORIGIN_Z: org_z_q <= cfg_data_i;
        CFG_COUNT:    count_q <= cfg_data_i[4:0];
        default:      ;
      endcase
    end
  end

  // sphere table
  entry_t          tbl_q [MAX_SPHERES];
  entry_t          rd_q;
  logic [31:0]     slot_ext;
  logic [KW-1:0]   k_q, n_lim;

  assign slot_ext = 32'(slot_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr && (slot_ext < MAX_SPHERES)) begin
      tbl_q[slot_ext[IW-1:0]] <= '{cx: point_x_i, cy: point_y_i, cz: point_z_i, r: radius_i};
    end
    if (cmd_i.rd_en) begin
      rd_q <= tbl_q[k_q[IW-1:0]];
    end
  end

  assign n_lim = (32'(count_q) > MAX_SPHERES) ? KW'(MAX_SPHERES) : KW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.ray_ld) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + 1'b1;
    end
  end

  // ray end point
  logic signed [COORD_W-1:0] end_x_q, end_y_q, end_z_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ray_ld) begin
      end_x_q <= point_x_i;
      end_y_q <= point_y_i;
      end_z_q <= point_z_i;
    end
  end

  logic signed [COORD_W:0] dx, dy, dz, ex, ey, ez;

  assign dx = 33'(end_x_q) - 33'(org_x_q);
  assign dy = 33'(end_y_q) - 33'(org_y_q);
  assign dz = 33'(end_z_q) - 33'(org_z_q);
  assign ex = 33'(org_x_q) - 33'($signed(rd_q.cx));
  assign ey = 33'(org_y_q) - 33'($signed(rd_q.cy));
  assign ez = 33'(org_z_q) - 33'($signed(rd_q.cz));

  // products: one 33x33 multiply per cycle into a product register, then accumulated
  logic signed [COORD_W:0]     ma, mb;
  logic signed [2*COORD_W+1:0] prod_q;
  logic [3:0]                  pstep_q;
  logic                        pvld_q;
  logic [WIDE_W-1:0]           a_q, ee_q;
  logic signed [WIDE_W:0]      h_q;
  logic [2*RAD_W-1:0]          rr_q;

  always_comb begin
    case (cmd_i.mul_step)
      4'd0:    begin ma = dx; mb = dx; end
      4'd1:    begin ma = dy; mb = dy; end
      4'd2:    begin ma = dz; mb = dz; end
      4'd3:    begin ma = ex; mb = ex; end
      4'd4:    begin ma = ey; mb = ey; end
      4'd5:    begin ma = ez; mb = ez; end
      4'd6:    begin ma = dx; mb = ex; end
      4'd7:    begin ma = dy; mb = ey; end
      4'd8:    begin ma = dz; mb = ez; end
      default: begin ma = 33'(rd_q.r); mb = 33'(rd_q.r); end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= cmd_i.mul_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= ma * mb;
    pstep_q <= cmd_i.mul_step;
    if (cmd_i.acc_clr) begin
      a_q  <= '0;
      ee_q <= '0;
      h_q  <= '0;
      rr_q <= '0;
    end else if (pvld_q) begin
      if (pstep_q < 4'(MS_EE)) begin
        a_q <= a_q + $unsigned(prod_q);
      end else if (pstep_q < 4'(MS_H)) begin
        ee_q <= ee_q + $unsigned(prod_q);
      end else if (pstep_q < 4'(MS_RR)) begin
        h_q <= h_q + (WIDE_W+1)'(prod_q);
      end else begin
        rr_q <= prod_q[2*RAD_W-1:0];
      end
    end
  end

  logic [WIDE_W-1:0] hm, cc;

  assign hm = WIDE_W'(-h_q);
  assign cc = ee_q - WIDE_W'(rr_q);

  assign sts_o.a_miss = (a_q == '0) || !h_q[WIDE_W] || (ee_q <= WIDE_W'(rr_q));

  // h*h and a*c, shift-add, one multiplier bit per cycle
  logic [WIDE_W-1:0] hm_q, mh_q, mc_q;
  logic [PW-1:0]     h2_q, ac_q, hsh_q, ash_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wmul_start) begin
      hm_q  <= hm;
      mh_q  <= hm;
      mc_q  <= cc;
      hsh_q <= PW'(hm);
      ash_q <= PW'(a_q);
      h2_q  <= '0;
      ac_q  <= '0;
    end else if (cmd_i.wmul_step) begin
      if (mh_q[0]) h2_q <= h2_q + hsh_q;
      if (mc_q[0]) ac_q <= ac_q + ash_q;
      mh_q  <= mh_q >> 1;
      mc_q  <= mc_q >> 1;
      hsh_q <= hsh_q << 1;
      ash_q <= ash_q << 1;
    end
  end

  assign sts_o.disc_miss = (h2_q < ac_q);

  // restoring square root, two radicand bits per cycle
  logic [PW-1:0]     x_q;
  logic [WIDE_W-1:0] root_q;
  logic [WIDE_W+2:0] srem_q, srem_n, trial;

  assign srem_n = {srem_q[WIDE_W:0], x_q[PW-1:PW-2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      x_q    <= h2_q - ac_q;
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      x_q <= x_q << 2;
      if (srem_n >= trial) begin
        srem_q <= srem_n - trial;
        root_q <= {root_q[WIDE_W-2:0], 1'b1};
      end else begin
        srem_q <= srem_n;
        root_q <= {root_q[WIDE_W-2:0], 1'b0};
      end
    end
  end

  assign sts_o.root_miss = (hm_q <= root_q);

  // restoring divide of ((|h| - s) << F) by a, one quotient bit per cycle
  logic [NW-1:0]     nsh_q, q_q;
  logic [WIDE_W:0]   drem_q, drem_n;
  logic [WIDE_W-1:0] hs;
  logic [30:0]       t_sat;

  assign hs     = hm_q - root_q;
  assign drem_n = {drem_q[WIDE_W-1:0], nsh_q[NW-1]};
  assign t_sat  = (q_q > NW'(T_MAX)) ? T_MAX : q_q[30:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      nsh_q  <= {hs, FRAC_BITS'(0)};
      q_q    <= '0;
      drem_q <= '0;
    end else if (cmd_i.div_step) begin
      nsh_q <= nsh_q << 1;
      if (drem_n >= (WIDE_W+1)'(a_q)) begin
        drem_q <= drem_n - (WIDE_W+1)'(a_q);
        q_q    <= {q_q[NW-2:0], 1'b1};
      end else begin
        drem_q <= drem_n;
        q_q    <= {q_q[NW-2:0], 1'b0};
      end
    end
  end

  // nearest hit so far
  logic          found_q;
  logic [KW-1:0] best_k_q;
  logic [30:0]   best_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      best_k_q <= '0;
      best_t_q <= '0;
    end else if (cmd_i.ray_ld) begin
      found_q  <= 1'b0;
      best_k_q <= '0;
      best_t_q <= '0;
    end else if (cmd_i.cand && (t_sat != '0) && (!found_q || (t_sat < best_t_q))) begin
      found_q  <= 1'b1;
      best_k_q <= k_q;
      best_t_q <= t_sat;
    end
  end

  assign sts_o.empty = (n_lim == '0);
  assign sts_o.last  = ((32'(k_q) + 32'd1) >= 32'(n_lim));

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      hit_o        <= found_q;
      hit_index_o  <= found_q ? 4'(best_k_q) : 4'd0;
      distance_t_o <= found_q ? best_t_q : 31'd0;
      red_o        <= (found_q && (best_k_q == KW'(0))) ? COLOR_ON : 8'd0;
      green_o      <= (found_q && (best_k_q == KW'(1))) ? COLOR_ON : 8'd0;
      blue_o       <= 8'd0;
    end
  end

  `RSCH_ASSERT_ALWAYS(a_found_t, found_q |-> (best_t_q != '0), "hit with zero distance")
  `RSCH_ASSERT(a_div_rem, cmd_i.div_step |-> (drem_q < (WIDE_W+1)'(a_q)), "divide remainder")
  `RSCH_ASSERT(a_sqrt_rem, cmd_i.sqrt_step |-> (srem_q <= (WIDE_W+3)'({root_q, 1'b0})),
               "sqrt remainder")

endmodule

@@ test/closest_hit_checker.sv @@
// Checker for ray_sphere_closest_hit: watches the config port and both channels,
// predicts each cast result and compares it field by field. Needs rsch_pkg.
module closest_hit_checker import rsch_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               cmd_i,
  input  logic [3:0]         slot_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic [30:0]        radius_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               hit_i,
  input  logic [3:0]         hit_index_i,
  input  logic [30:0]        distance_t_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output int                 err_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int DEPTH = 16;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic        hit;
    logic [3:0]  idx;
    logic [30:0] distance;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } hit_t;

  logic signed [31:0] org_x, org_y, org_z;
  logic [4:0]         sph_count;
  logic signed [31:0] cen_x [DEPTH];
  logic signed [31:0] cen_y [DEPTH];
  logic signed [31:0] cen_z [DEPTH];
  logic [30:0]        rad   [DEPTH];
  hit_t               hit_queue [$];

  function automatic wide_t isqrt(wide_t x);
    wide_t num, res, bitv;
    num = x;
    res = '0;
    bitv = wide_t'(1) <<< 252;
    while (bitv != 0 && bitv > num) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (num >= res + bitv) begin
        num = num - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic hit_t nearest_hit(logic signed [31:0] ex, logic signed [31:0] ey,
                                       logic signed [31:0] ez);
    hit_t r;
    wide_t dx, dy, dz, qx, qy, qz, a, h, ee, rr, c, disc, s, nh, q;
    logic [30:0] t, best_t;
    int n, best;
    logic found;
    found = 1'b0;
    best = 0;
    best_t = '0;
    n = (sph_count > DEPTH) ? DEPTH : sph_count;
    dx = wide_t'(longint'(ex) - longint'(org_x));
    dy = wide_t'(longint'(ey) - longint'(org_y));
    dz = wide_t'(longint'(ez) - longint'(org_z));
    for (int k = 0; k < n; k++) begin
      qx = wide_t'(longint'(org_x) - longint'(cen_x[k]));
      qy = wide_t'(longint'(org_y) - longint'(cen_y[k]));
      qz = wide_t'(longint'(org_z) - longint'(cen_z[k]));
      a = dx * dx + dy * dy + dz * dz;
      h = dx * qx + dy * qy + dz * qz;
      ee = qx * qx + qy * qy + qz * qz;
      rr = wide_t'({1'b0, rad[k]}) * wide_t'({1'b0, rad[k]});
      if (a == 0 || h >= 0 || ee <= rr) continue;
      c = ee - rr;
      disc = h * h - a * c;
      if (disc < 0) continue;
      s = isqrt(disc);
      nh = -h;
      if (nh <= s) continue;
      q = ((nh - s) <<< FRAC) / a;
      t = (q > wide_t'({1'b0, T_MAX})) ? T_MAX : q[30:0];
      if (t == 0) continue;
      if (!found || t < best_t) begin
        found = 1'b1;
        best = k;
        best_t = t;
      end
    end
    r.hit = found;
    r.idx = found ? best[3:0] : 4'd0;
    r.distance = found ? best_t : 31'd0;
    r.red = (found && best == 0) ? COLOR_ON : 8'd0;
    r.green = (found && best == 1) ? COLOR_ON : 8'd0;
    r.blue = 8'd0;
    return r;
  endfunction

  always @(negedge clk_i) begin
    hit_t e;
    if (!rst_ni) begin
      org_x = '0;
      org_y = '0;
      org_z = '0;
      sph_count = '0;
      err_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ORIGIN_X: org_x = cfg_data_i;
          CFG_ORIGIN_Y: org_y = cfg_data_i;
          CFG_ORIGIN_Z: org_z = cfg_data_i;
          CFG_COUNT:    sph_count = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == CMD_LOAD) begin
          cen_x[slot_i] = point_x_i;
          cen_y[slot_i] = point_y_i;
          cen_z[slot_i] = point_z_i;
          rad[slot_i] = radius_i;
        end else begin
          hit_queue.push_back(nearest_hit(point_x_i, point_y_i, point_z_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (hit_queue.size() == 0) begin
          $error("result with no cast waiting");
          err_count_o++;
        end else begin
          e = hit_queue.pop_front();
          if (hit_i !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, hit_i);
            err_count_o++;
          end
          if (hit_index_i !== e.idx) begin
            $error("hit_index: expected %0d, got %0d", e.idx, hit_index_i);
            err_count_o++;
          end
          if (distance_t_i !== e.distance) begin
            $error("distance_t: expected %0d, got %0d", e.distance, distance_t_i);
            err_count_o++;
          end
          if (red_i !== e.red) begin
            $error("red: expected %0d, got %0d", e.red, red_i);
            err_count_o++;
          end
          if (green_i !== e.green) begin
            $error("green: expected %0d, got %0d", e.green, green_i);
            err_count_o++;
          end
          if (blue_i !== e.blue) begin
            $error("blue: expected %0d, got %0d", e.blue, blue_i);
            err_count_o++;
          end
        end
      end
      pending_o = hit_queue.size();
    end
  end
endmodule

@@ test/testbench.sv @@
// Top of the ray_sphere_closest_hit testbench: clock, reset, config phases,
// directed and random load/cast items. Needs rsch_pkg and closest_hit_checker.
module testbench import rsch_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 65536;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               cmd_i = CMD_LOAD;
  logic [3:0]         slot_i = '0;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic signed [31:0] point_z_i = '0;
  logic [30:0]        radius_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               hit_o;
  logic [3:0]         hit_index_o;
  logic [30:0]        distance_t_o;
  logic [7:0]         red_o, green_o, blue_o;
  int                 err_count, pending;

  logic               quiet = 1'b0;
  int                 stall_left = 0;
  int                 cen_x [16], cen_y [16], cen_z [16];
  int                 active = 0;

  ray_sphere_closest_hit u_top (.*);

  closest_hit_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .cmd_i, .slot_i,
    .point_x_i, .point_y_i, .point_z_i, .radius_i,
    .out_valid_i(out_valid_o), .out_stall_i, .hit_i(hit_o),
    .hit_index_i(hit_index_o), .distance_t_i(distance_t_o),
    .red_i(red_o), .green_i(green_o), .blue_i(blue_o),
    .err_count_o(err_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && !out_stall_i) begin
      out_stall_i <= 1'b1;
      stall_left <= gap_len();
    end else begin
      out_stall_i <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end
  end

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic write_config(int ox, int oy, int oz, int cnt);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_ORIGIN_X;
    cfg_data_i <= ox;
    @(posedge clk_i);
    cfg_idx_i <= CFG_ORIGIN_Y;
    cfg_data_i <= oy;
    @(posedge clk_i);
    cfg_idx_i <= CFG_ORIGIN_Z;
    cfg_data_i <= oz;
    @(posedge clk_i);
    cfg_idx_i <= CFG_COUNT;
    cfg_data_i <= cnt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    active = (cnt > 16) ? 16 : cnt;
  endtask

  task automatic send(logic cmd, logic [3:0] slot, int px, int py, int pz, logic [30:0] rad);
    logic st;
    int g;
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    slot_i <= slot;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    radius_i <= rad;
    if (cmd == CMD_LOAD) begin
      cen_x[slot] = px;
      cen_y[slot] = py;
      cen_z[slot] = pz;
    end
    forever begin
      @(negedge clk_i);
      st = in_stall_o;
      @(posedge clk_i);
      if (!st) break;
    end
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_item();
    int r, k;
    r = $urandom_range(0, 99);
    k = (active > 0) ? $urandom_range(0, active - 1) : 0;
    if (r < 8) begin
      send(CMD_LOAD, 4'($urandom), $urandom, $urandom, $urandom, 31'($urandom));
    end else if (r < 25) begin
      send(CMD_LOAD, 4'($urandom), jitter(50 * ONE), jitter(50 * ONE), jitter(50 * ONE),
           31'($urandom_range(ONE / 4, 8 * ONE)));
    end else if (r < 35) begin
      send(CMD_CAST, 4'($urandom), $urandom, $urandom, $urandom, 31'($urandom));
    end else begin
      send(CMD_CAST, 4'($urandom), cen_x[k] + jitter(2 * ONE), cen_y[k] + jitter(2 * ONE),
           cen_z[k] + jitter(2 * ONE), 31'($urandom));
    end
  endtask

  initial begin
    int cnts [10] = '{1, 2, 3, 4, 16, 2, 31, 0, 3, 1};
    int ox, oy, oz, len;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_config(0, 0, 0, 16);
    quiet = 1'b1;
    send(CMD_LOAD, 4'd0, 0, 0, 10 * ONE, 31'(ONE));
    send(CMD_LOAD, 4'd1, 0, 0, 5 * ONE, 31'(ONE));
    send(CMD_LOAD, 4'd2, 8 * ONE, 0, 0, 31'(ONE));
    send(CMD_LOAD, 4'd3, 8 * ONE, 0, 0, 31'(ONE));
    send(CMD_LOAD, 4'd4, 0, 1000 * ONE, 0, 31'(ONE));
    send(CMD_LOAD, 4'd5, 0, 1000 * ONE, 0, 31'(ONE));
    for (int s = 6; s < 16; s++)
      send(CMD_LOAD, 4'(s), jitter(20 * ONE), jitter(20 * ONE), -30 * ONE,
           31'($urandom_range(ONE, 4 * ONE)));
    quiet = 1'b0;
    send(CMD_CAST, 4'd0, 0, 0, ONE, 31'h7FFF_FFFF);           // green, nearer sphere
    send(CMD_CAST, 4'd15, ONE, 0, 0, '0);                      // equal spheres tie
    send(CMD_CAST, 4'd0, 0, 1, 0, '0);                         // saturated tie
    send(CMD_CAST, 4'd0, 0, 0, 0, '0);                         // zero-length ray
    send(CMD_CAST, 4'd0, 0, 0, -ONE, '0);                      // pointing away
    send(CMD_CAST, 4'd0, 0, 3 * ONE, ONE, '0);                 // grazes past
    send(CMD_CAST, 4'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
    send(CMD_CAST, 4'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
    drain();
    write_config(0, 0, 10 * ONE, 2);                           // origin inside sphere 0
    send(CMD_CAST, 4'd0, 0, 0, 11 * ONE, '0);
    drain();
    write_config(0, 0, -2 * ONE, 1);                           // red
    send(CMD_CAST, 4'd0, 0, 0, 0, '0);
    drain();
    write_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send(CMD_CAST, 4'd0, 0, 0, 0, '0);
    drain();
    write_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31);
    send(CMD_CAST, 4'd0, 0, 0, 0, '0);
    send(CMD_CAST, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    drain();

    for (int p = 0; p < 10; p++) begin
      if (p == 3) begin
        ox = 32'h7FFF_FFFF;
        oy = 32'h8000_0000;
        oz = $urandom;
      end else begin
        ox = jitter(60 * ONE);
        oy = jitter(60 * ONE);
        oz = jitter(60 * ONE);
      end
      quiet = (p == 5);
      write_config(ox, oy, oz, cnts[p]);
      len = (cnts[p] >= 16) ? 40 : 170;
      for (int i = 0; i < len; i++) random_item();
      drain();
    end

    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
